/* rtl/assert_macros.svh */
// Assertion macros shared by the one-wire master RTL.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define OWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/owm_pkg.sv */
// Types, codes and reset values for the one-wire bus master.
// No dependencies; used by every module of the block.
package owm_pkg;

    // request type codes carried with each tick
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [2:0] CFG_RESET_RELEASE = 3'd1;
    localparam logic [2:0] CFG_POLL_PERIOD   = 3'd2;
    localparam logic [2:0] CFG_POLL_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_SLOT_TIME     = 3'd4;
    localparam logic [2:0] CFG_SHORT_PULSE   = 3'd5;
    localparam logic [2:0] CFG_SAMPLE_DELAY  = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register reset values
    localparam logic [11:0] RST_RESET_LOW     = 12'd500;
    localparam logic [11:0] RST_RESET_RELEASE = 12'd20;
    localparam logic [11:0] RST_POLL_PERIOD   = 12'd10;
    localparam logic [7:0]  RST_POLL_LIMIT    = 8'd25;
    localparam logic [11:0] RST_SLOT_TIME     = 12'd60;
    localparam logic [7:0]  RST_SHORT_PULSE   = 8'h01;
    localparam logic [7:0]  RST_SAMPLE_DELAY  = 8'h01;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_REL   = 4'd2,
        PH_PRES_LOW  = 4'd3,
        PH_PRES_HIGH = 4'd4,
        PH_W_LOW     = 4'd5,
        PH_W_HIGH    = 4'd6,
        PH_R_LOW     = 4'd7,
        PH_R_WAIT    = 4'd8,
        PH_R_REST    = 4'd9
    } t_owm_phase;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_data;
        logic       line_level;
    } t_owm_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       status;
        logic [7:0] read_data;
    } t_owm_res;

    typedef struct packed {
        logic [11:0] reset_low_time;
        logic [11:0] reset_release_time;
        logic [11:0] presence_poll_period;
        logic [7:0]  presence_poll_limit;
        logic [11:0] slot_time;
        logic [7:0]  short_pulse_time;
        logic [7:0]  sample_delay;
    } t_owm_cfg;

    typedef struct packed {
        t_owm_phase  phase;
        logic [11:0] tick_timer;
        logic [7:0]  poll_count;
        logic [2:0]  bit_index;
        logic [7:0]  shift_reg;
        logic [7:0]  last_read;
        logic        last_status;
    } t_owm_state;

endpackage

/* rtl/one_wire_bus_master_core.sv */
// Top level of the one-wire bus master: input register, tick logic, result register.
// Depends on owm_pkg, owm_cfg_regs, owm_step and assert_macros.svh.
//
//  channel | direction | payload     | handshake
//  --------+-----------+-------------+------------------------------
//  in      | to block  | t_owm_in    | i_in_valid / o_in_stall
//  out     | from block| t_owm_res   | o_out_valid / i_out_stall
//  cfg     | to block  | 12-bit data | i_cfg_we, index i_cfg_idx
//
// One tick per cycle while the result side does not stall: a request passes
// through the input register, then leaves from the result register.
// The bus state advances only when a request moves into the result register.
// A stall on the result side holds both stages; the input stage still takes
// a request while its slot is empty. Synchronous reset clears state and valids.
`include "assert_macros.svh"

module one_wire_bus_master_core
    import owm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_owm_in               i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_owm_res              o_out_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_owm_cfg   cfg;
    t_owm_state r_state;
    t_owm_state n_state;
    t_owm_res   n_res;
    t_owm_res   r_out;
    t_owm_in    r_in;
    logic       r_in_valid;
    logic       r_out_valid;
    logic       advance;
    logic       in_load;

    owm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    owm_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // move a request on when the result slot is free or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || advance;
    assign o_in_stall = !in_load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    // bus state and result register, updated together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_IDLE;
            r_state.tick_timer  <= 12'd0;
            r_state.poll_count  <= 8'd0;
            r_state.bit_index   <= 3'd0;
            r_state.shift_reg   <= 8'd0;
            r_state.last_read   <= 8'd0;
            r_state.last_status <= 1'b0;
            r_out_valid         <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // checks on the block's own logic
    `OWM_ASSERT_NOW(a_done_not_busy, r_out_valid && r_out.done_res, !r_out.busy_res, "done with busy")
    `OWM_ASSERT_NOW(a_drive_busy, r_out_valid && r_out.drive_low, r_out.busy_res, "drive while idle")
    `OWM_ASSERT_NOW(a_idle_match, r_out_valid && !r_out.busy_res, r_state.phase == PH_IDLE, "phase mismatch")
    `OWM_ASSERT_NEXT(a_in_hold, r_in_valid && !advance, r_in_valid && $stable(r_in), "request lost")

endmodule

/* rtl/owm_cfg_regs.sv */
// Configuration register file of the one-wire bus master.
// Depends on owm_pkg for register indexes, reset values and the cfg struct.
module owm_cfg_regs
    import owm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_owm_cfg              o_cfg
);

    t_owm_cfg r_cfg;

    // write one register per request, drop bits above its width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time       <= RST_RESET_LOW;
            r_cfg.reset_release_time   <= RST_RESET_RELEASE;
            r_cfg.presence_poll_period <= RST_POLL_PERIOD;
            r_cfg.presence_poll_limit  <= RST_POLL_LIMIT;
            r_cfg.slot_time            <= RST_SLOT_TIME;
            r_cfg.short_pulse_time     <= RST_SHORT_PULSE;
            r_cfg.sample_delay         <= RST_SAMPLE_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESET_LOW:     r_cfg.reset_low_time       <= i_cfg_data;
                CFG_RESET_RELEASE: r_cfg.reset_release_time   <= i_cfg_data;
                CFG_POLL_PERIOD:   r_cfg.presence_poll_period <= i_cfg_data;
                CFG_POLL_LIMIT:    r_cfg.presence_poll_limit  <= i_cfg_data[7:0];
                CFG_SLOT_TIME:     r_cfg.slot_time            <= i_cfg_data;
                CFG_SHORT_PULSE:   r_cfg.short_pulse_time     <= i_cfg_data[7:0];
                CFG_SAMPLE_DELAY:  r_cfg.sample_delay         <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/owm_step.sv */
// Next-state and result logic for one bus tick of the one-wire master.
// Purely combinational; depends on owm_pkg for phase, state and payload types.
module owm_step
    import owm_pkg::*;
(
    input  t_owm_state i_state,
    input  t_owm_in    i_item,
    input  t_owm_cfg   i_cfg,
    output t_owm_state o_state,
    output t_owm_res   o_res
);

    always_comb begin
        t_owm_state  n_st;
        logic        drive;
        logic        done;
        logic        expired;
        logic        want;
        logic [11:0] dec;
        logic [11:0] short_len;

        n_st      = i_state;
        drive     = 1'b0;
        done      = 1'b0;
        short_len = {4'd0, i_cfg.short_pulse_time};

        // start a command on an idle bus; the arrival tick is its first tick
        if (i_state.phase == PH_IDLE && i_item.req_type != REQ_TICK) begin
            n_st.bit_index = 3'd0;
            case (i_item.req_type)
                REQ_RESET: begin
                    n_st.phase      = PH_RST_LOW;
                    n_st.tick_timer = i_cfg.reset_low_time;
                end
                REQ_WRITE: begin
                    n_st.shift_reg  = i_item.write_data;
                    n_st.phase      = PH_W_LOW;
                    n_st.tick_timer = i_item.write_data[0] ? short_len : i_cfg.slot_time;
                end
                REQ_READ: begin
                    n_st.shift_reg  = 8'd0;
                    n_st.phase      = PH_R_LOW;
                    n_st.tick_timer = short_len;
                end
                default: begin
                end
            endcase
        end

        // a timed phase ends when its timer is down to one or zero
        expired = (n_st.tick_timer <= 12'd1);
        dec     = n_st.tick_timer - 12'd1;
        want    = (n_st.phase == PH_PRES_HIGH);

        case (n_st.phase)
            PH_IDLE: begin
            end
            PH_RST_LOW: begin
                drive = 1'b1;
                if (!expired) begin
                    n_st.tick_timer = dec;
                end else begin
                    n_st.phase      = PH_RST_REL;
                    n_st.tick_timer = i_cfg.reset_release_time;
                end
            end
            PH_RST_REL: begin
                if (!expired) begin
                    n_st.tick_timer = dec;
                end else begin
                    n_st.phase      = PH_PRES_LOW;
                    n_st.tick_timer = 12'd0;
                    n_st.poll_count = 8'd0;
                end
            end
            PH_PRES_LOW, PH_PRES_HIGH: begin
                // wait out the poll period, then sample the line
                if (n_st.tick_timer != 12'd0) begin
                    n_st.tick_timer = dec;
                end else if (i_item.line_level == want) begin
                    if (n_st.phase == PH_PRES_LOW) begin
                        n_st.phase      = PH_PRES_HIGH;
                        n_st.poll_count = 8'd0;
                        n_st.tick_timer = 12'd0;
                    end else begin
                        n_st.last_status = 1'b0;
                        n_st.phase       = PH_IDLE;
                        done             = 1'b1;
                    end
                end else if (n_st.poll_count >= i_cfg.presence_poll_limit) begin
                    n_st.last_status = 1'b1;
                    n_st.phase       = PH_IDLE;
                    done             = 1'b1;
                end else begin
                    n_st.poll_count = n_st.poll_count + 8'd1;
                    n_st.tick_timer = (i_cfg.presence_poll_period != 12'd0) ?
                                      i_cfg.presence_poll_period - 12'd1 : 12'd0;
                end
            end
            PH_W_LOW: begin
                drive = 1'b1;
                if (!expired) begin
                    n_st.tick_timer = dec;
                end else begin
                    n_st.phase      = PH_W_HIGH;
                    n_st.tick_timer = n_st.shift_reg[0] ? i_cfg.slot_time : short_len;
                end
            end
            PH_W_HIGH: begin
                if (!expired) begin
                    n_st.tick_timer = dec;
                end else begin
                    n_st.shift_reg = {1'b0, n_st.shift_reg[7:1]};
                    if (n_st.bit_index == 3'd7) begin
                        n_st.phase = PH_IDLE;
                        done       = 1'b1;
                    end else begin
                        n_st.bit_index  = n_st.bit_index + 3'd1;
                        n_st.phase      = PH_W_LOW;
                        n_st.tick_timer = n_st.shift_reg[0] ? short_len : i_cfg.slot_time;
                    end
                end
            end
            PH_R_LOW: begin
                drive = 1'b1;
                if (!expired) begin
                    n_st.tick_timer = dec;
                end else begin
                    n_st.phase      = PH_R_WAIT;
                    n_st.tick_timer = {4'd0, i_cfg.sample_delay};
                end
            end
            PH_R_WAIT: begin
                // sample on the last released tick, shift in from the top
                if (!expired) begin
                    n_st.tick_timer = dec;
                end else begin
                    n_st.shift_reg  = {i_item.line_level, n_st.shift_reg[7:1]};
                    n_st.phase      = PH_R_REST;
                    n_st.tick_timer = i_cfg.slot_time;
                end
            end
            PH_R_REST: begin
                if (!expired) begin
                    n_st.tick_timer = dec;
                end else if (n_st.bit_index == 3'd7) begin
                    n_st.last_read = n_st.shift_reg;
                    n_st.phase     = PH_IDLE;
                    done           = 1'b1;
                end else begin
                    n_st.bit_index  = n_st.bit_index + 3'd1;
                    n_st.phase      = PH_R_LOW;
                    n_st.tick_timer = short_len;
                end
            end
            default: begin
                n_st.phase = PH_IDLE;
            end
        endcase

        o_state           = n_st;
        o_res.drive_low   = drive;
        o_res.busy_res    = (n_st.phase != PH_IDLE);
        o_res.done_res    = done;
        o_res.status      = n_st.last_status;
        o_res.read_data   = n_st.last_read;
    end

endmodule
